>>> hdl/encd_pkg.sv
// Shared types and constants for the elastic-net coordinate descent engine.
// Used by elastic_net_coordinate_descent; no dependencies.
`default_nettype none

package encd_pkg;

    // Port field widths
    localparam int DATA_W     = 32;
    localparam int IDX_W      = 5;
    localparam int ROUND_W    = 16;
    localparam int FUNC_W     = 2;
    localparam int ROW_W      = 10;
    localparam int COL_W      = 5;
    localparam int CFG_IDX_W  = 3;

    // Register widths
    localparam int LAMBDA_W   = 31;
    localparam int ALPHA_W    = 17;
    localparam int TOL_W      = 31;
    localparam int ROWCNT_W   = 11;
    localparam int COLCNT_W   = 6;

    // Datapath widths
    localparam int OPND_W     = 33;   // signed multiplier operand
    localparam int MAG_W      = 32;   // operand magnitude
    localparam int PROD_W     = 64;
    localparam int ACC_W      = 66;
    localparam int DVD_W      = 64;
    localparam int DVS_W      = 33;
    localparam int REM_W      = 34;
    localparam int DIV_CNT_W  = 6;

    // alpha is Q1.16 (unsigned, up to one) regardless of the data format
    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
    localparam int                 ALPHA_SHIFT = 16;
    localparam logic [PROD_W-1:0]  ALPHA_HALF  = 64'd32768;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD_X    = 2'd0,
        FUNC_LOAD_Y    = 2'd1,
        FUNC_LOAD_COEF = 2'd2,
        FUNC_RUN       = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LAMBDA     = 3'd0,
        REG_ALPHA      = 3'd1,
        REG_TOL        = 3'd2,
        REG_MAX_ROUNDS = 3'd3,
        REG_ROW_COUNT  = 3'd4,
        REG_COL_COUNT  = 3'd5
    } cfg_reg_t;

    localparam logic [LAMBDA_W-1:0] LAMBDA_RST     = 31'd65536;
    localparam logic [ALPHA_W-1:0]  ALPHA_RST      = 17'd32768;
    localparam logic [TOL_W-1:0]    TOL_RST        = 31'd66;
    localparam logic [ROUND_W-1:0]  MAX_ROUNDS_RST = 16'd1000;
    localparam logic [ROWCNT_W-1:0] ROW_COUNT_RST  = 11'd1024;
    localparam logic [COLCNT_W-1:0] COL_COUNT_RST  = 6'd32;

endpackage

`default_nettype wire

>>> hdl/encd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module encd_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> hdl/elastic_net_coordinate_descent.sv
// Elastic-net coordinate descent engine: sequencer, shared multiplier and divider.
// Depends on encd_pkg and encd_ram.
//
// Usage:
//   Input channel (s_*): func 0/1/2 loads an x element, a y value or an initial
//   coefficient; each load is taken while the block stays idle, so loads stream back to back.
//   Func 3 starts a fit; s_ready stays low until the last result is taken.
//   Config channel (cfg_*): always ready; write only while the block is idle.
//   Result channel (m_*): one item per feature in use, index order; the last one
//   carries rounds_done and last=1. A stalled receiver simply holds the block.
// Sequence of a fit, with n rows and d columns in use:
//   setup, then residual init over all n rows and d columns, then per round and
//   active column a dot product through the one multiplier, a mean divide,
//   a shrink divide if the coefficient stays nonzero and a residual update if it changed.
//   The divider is bit-serial, one quotient bit a cycle.
//   Results then leave at one per cycle while the receiver does not stall.
// Reset: synchronous active low; clears the sequencer, round state and registers
//   to their defaults. Sample, target, residual and coefficient stores are not
//   cleared and must be loaded before use; there is no clearing pass.
`default_nettype none

module elastic_net_coordinate_descent #(
    parameter int ROWS_MAX  = 1024,
    parameter int COLS_MAX  = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [encd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [encd_pkg::DATA_W-1:0]          cfg_data,

    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [encd_pkg::FUNC_W-1:0]          s_func,
    input  wire logic [encd_pkg::ROW_W-1:0]           s_row,
    input  wire logic [encd_pkg::COL_W-1:0]           s_column,
    input  wire logic signed [encd_pkg::DATA_W-1:0]   s_value,

    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [encd_pkg::IDX_W-1:0]                m_coef_index,
    output logic signed [encd_pkg::DATA_W-1:0]        m_coef_value,
    output logic [encd_pkg::ROUND_W-1:0]              m_rounds_done,
    output logic                                      m_last
);

    localparam int DW   = encd_pkg::DATA_W;
    localparam int AW   = encd_pkg::ACC_W;
    localparam int RW   = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
    localparam int CW   = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
    localparam int NW   = $clog2(ROWS_MAX + 1);
    localparam int XD   = ROWS_MAX * COLS_MAX;
    localparam int XAW  = (XD > 1) ? $clog2(XD) : 1;
    localparam logic [encd_pkg::PROD_W-1:0] MUL_HALF =
        encd_pkg::PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [encd_pkg::DVS_W-1:0] DEN_ONE =
        encd_pkg::DVS_W'(1) << FRAC_BITS;
    localparam logic [encd_pkg::DIV_CNT_W-1:0] DIV_LAST =
        encd_pkg::DIV_CNT_W'(encd_pkg::DVD_W - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_LAM1, S_LAM2, S_LAM3,
        S_RI_Y_ADDR, S_RI_Y_LOAD, S_RI_X_ADDR, S_RI_X_MUL, S_RI_X_ACC, S_RI_WRITE,
        S_ROUND_CHECK, S_COL_CHECK, S_CD_ADDR, S_CD_MUL, S_CD_ACC, S_SUM_DIV,
        S_DIV, S_Z, S_Z2, S_NV, S_DELTA,
        S_RU_ADDR, S_RU_MUL, S_RU_WRITE, S_COL_NEXT, S_ROUND_END, S_OUT
    } state_t;

    function automatic logic [DW-1:0] sat32(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] hi;
        logic signed [AW-1:0] lo;
        hi = {{(AW-DW+1){1'b0}}, {(DW-1){1'b1}}};
        lo = {{(AW-DW+1){1'b1}}, {(DW-1){1'b0}}};
        if (v > hi) begin
            return hi[DW-1:0];
        end else if (v < lo) begin
            return lo[DW-1:0];
        end
        return v[DW-1:0];
    endfunction

    // ---------------- configuration registers ----------------
    logic [encd_pkg::LAMBDA_W-1:0] lambda_reg;
    logic [encd_pkg::ALPHA_W-1:0]  alpha_reg;
    logic [encd_pkg::TOL_W-1:0]    tol_reg;
    logic [encd_pkg::ROUND_W-1:0]  max_rounds_reg;
    logic [encd_pkg::ROWCNT_W-1:0] row_count_reg;
    logic [encd_pkg::COLCNT_W-1:0] col_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lambda_reg     <= encd_pkg::LAMBDA_RST;
            alpha_reg      <= encd_pkg::ALPHA_RST;
            tol_reg        <= encd_pkg::TOL_RST;
            max_rounds_reg <= encd_pkg::MAX_ROUNDS_RST;
            row_count_reg  <= encd_pkg::ROW_COUNT_RST;
            col_count_reg  <= encd_pkg::COL_COUNT_RST;
        end else if (cfg_valid) begin
            unique case (encd_pkg::cfg_reg_t'(cfg_index))
                encd_pkg::REG_LAMBDA:     lambda_reg     <= cfg_data[encd_pkg::LAMBDA_W-1:0];
                encd_pkg::REG_ALPHA:      alpha_reg      <= cfg_data[encd_pkg::ALPHA_W-1:0];
                encd_pkg::REG_TOL:        tol_reg        <= cfg_data[encd_pkg::TOL_W-1:0];
                encd_pkg::REG_MAX_ROUNDS: max_rounds_reg <= cfg_data[encd_pkg::ROUND_W-1:0];
                encd_pkg::REG_ROW_COUNT:  row_count_reg  <= cfg_data[encd_pkg::ROWCNT_W-1:0];
                encd_pkg::REG_COL_COUNT:  col_count_reg  <= cfg_data[encd_pkg::COLCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- sequencer and datapath registers ----------------
    state_t state_reg, state_next;
    logic [RW-1:0]  i_reg, i_next;
    logic [CW-1:0]  j_reg, j_next;
    logic [RW-1:0]  n_m1_reg, n_m1_next;
    logic [NW-1:0]  n_reg, n_next;
    logic [CW-1:0]  d_m1_reg, d_m1_next;
    logic [encd_pkg::ROUND_W-1:0] rounds_reg, rounds_next;
    logic           active_only_reg, active_only_next;
    logic           exceeded_reg, exceeded_next;
    logic [COLS_MAX-1:0] inactive_reg, inactive_next;

    logic signed [AW-1:0]           acc_reg, acc_next;
    logic [encd_pkg::PROD_W-1:0]    prod_reg, prod_next;
    logic                           prod_neg_reg, prod_neg_next;
    logic [DW-1:0]                  l1_reg, l1_next;
    logic [encd_pkg::DVS_W-1:0]     den_reg, den_next;
    logic [DW-1:0]                  z_reg, z_next;
    logic [DW-1:0]                  nv_reg, nv_next;
    logic signed [encd_pkg::OPND_W-1:0] delta_reg, delta_next;

    logic [encd_pkg::DVD_W-1:0]     dvd_reg, dvd_next;
    logic [encd_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic [encd_pkg::DVS_W-1:0]     dvs_reg, dvs_next;
    logic [encd_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                           div_neg_reg, div_neg_next;
    logic                           div_phase_reg, div_phase_next;

    // coefficient store: one read place, indexed by j
    logic [DW-1:0] coef_mem [COLS_MAX];
    logic          coef_we;
    logic [CW-1:0] coef_wsel;
    logic [DW-1:0] coef_wdata;
    logic [DW-1:0] coef_rd;

    always_ff @(posedge aclk) begin
        if (coef_we) begin
            coef_mem[coef_wsel] <= coef_wdata;
        end
    end
    assign coef_rd = coef_mem[j_reg];

    // ---------------- memories ----------------
    logic           x_we, y_we, r_we;
    logic [XAW-1:0] x_waddr, x_raddr;
    logic [DW-1:0]  x_rdata, y_rdata, r_rdata, r_wdata;

    assign x_waddr = XAW'(32'(s_column) * ROWS_MAX + 32'(s_row));
    assign x_raddr = XAW'(32'(j_reg) * ROWS_MAX + 32'(i_reg));

    encd_ram #(.WIDTH(DW), .DEPTH(XD)) u_x_ram (
        .aclk    (aclk),
        .wr_en   (x_we),
        .wr_addr (x_waddr),
        .wr_data (s_value),
        .rd_addr (x_raddr),
        .rd_data (x_rdata)
    );

    encd_ram #(.WIDTH(DW), .DEPTH(ROWS_MAX)) u_y_ram (
        .aclk    (aclk),
        .wr_en   (y_we),
        .wr_addr (RW'(s_row)),
        .wr_data (s_value),
        .rd_addr (i_reg),
        .rd_data (y_rdata)
    );

    encd_ram #(.WIDTH(DW), .DEPTH(ROWS_MAX)) u_res_ram (
        .aclk    (aclk),
        .wr_en   (r_we),
        .wr_addr (i_reg),
        .wr_data (r_wdata),
        .rd_addr (i_reg),
        .rd_data (r_rdata)
    );

    // ---------------- shared multiplier ----------------
    logic signed [encd_pkg::OPND_W-1:0] mul_a, mul_b;
    logic [encd_pkg::OPND_W-1:0]        mul_a_neg, mul_b_neg;
    logic [encd_pkg::MAG_W-1:0]         mul_a_mag, mul_b_mag;
    logic [encd_pkg::PROD_W-1:0]        mul_prod;
    logic                               mul_neg;

    assign mul_a_neg = -mul_a;
    assign mul_b_neg = -mul_b;
    assign mul_a_mag = mul_a[encd_pkg::OPND_W-1] ? mul_a_neg[encd_pkg::MAG_W-1:0]
                                                 : mul_a[encd_pkg::MAG_W-1:0];
    assign mul_b_mag = mul_b[encd_pkg::OPND_W-1] ? mul_b_neg[encd_pkg::MAG_W-1:0]
                                                 : mul_b[encd_pkg::MAG_W-1:0];
    assign mul_prod  = encd_pkg::PROD_W'(mul_a_mag) * encd_pkg::PROD_W'(mul_b_mag);
    assign mul_neg   = mul_a[encd_pkg::OPND_W-1] ^ mul_b[encd_pkg::OPND_W-1];

    // ---------------- derived values ----------------
    logic [encd_pkg::PROD_W-1:0] mul_rnd, lam_rnd;
    logic signed [AW-1:0]        mulq, q_s, old_ext, acc_neg;
    logic [AW-1:0]               acc_mag;
    logic signed [DW:0]          z33, nv33, old33, delta_calc;
    logic [DW:0]                 z_mag, z_diff, delta_mag;
    logic [encd_pkg::REM_W-1:0]  rem_sh, rem_sub;
    logic                        rem_ge;
    logic [encd_pkg::ALPHA_W-1:0] alpha_c;
    logic [31:0]                 n_full, d_full;

    assign mul_rnd = (prod_reg + MUL_HALF) >> FRAC_BITS;
    assign lam_rnd = (prod_reg + encd_pkg::ALPHA_HALF) >> encd_pkg::ALPHA_SHIFT;
    assign mulq    = prod_neg_reg ? -$signed({2'b00, mul_rnd}) : $signed({2'b00, mul_rnd});
    assign q_s     = div_neg_reg ? -$signed({2'b00, dvd_reg}) : $signed({2'b00, dvd_reg});
    assign old_ext = {{(AW-DW){coef_rd[DW-1]}}, coef_rd};
    assign acc_neg = -acc_reg;
    assign acc_mag = acc_reg[AW-1] ? acc_neg : acc_reg;

    assign z33    = {z_reg[DW-1], z_reg};
    assign z_mag  = z_reg[DW-1] ? -z33 : z33;
    assign z_diff = z_mag - {1'b0, l1_reg};

    assign nv33       = {nv_reg[DW-1], nv_reg};
    assign old33      = {coef_rd[DW-1], coef_rd};
    assign delta_calc = nv33 - old33;
    assign delta_mag  = delta_calc[DW] ? -delta_calc : delta_calc;

    assign rem_sh  = {rem_reg[encd_pkg::REM_W-2:0], dvd_reg[encd_pkg::DVD_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    assign alpha_c = (alpha_reg > encd_pkg::ALPHA_ONE) ? encd_pkg::ALPHA_ONE : alpha_reg;

    always_comb begin
        if (row_count_reg == '0) begin
            n_full = 32'd1;
        end else if (32'(row_count_reg) > ROWS_MAX) begin
            n_full = 32'(ROWS_MAX);
        end else begin
            n_full = 32'(row_count_reg);
        end
        if (col_count_reg == '0) begin
            d_full = 32'd1;
        end else if (32'(col_count_reg) > COLS_MAX) begin
            d_full = 32'(COLS_MAX);
        end else begin
            d_full = 32'(col_count_reg);
        end
    end

    // ---------------- next-state logic ----------------
    always_comb begin
        state_next       = state_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        n_m1_next        = n_m1_reg;
        n_next           = n_reg;
        d_m1_next        = d_m1_reg;
        rounds_next      = rounds_reg;
        active_only_next = active_only_reg;
        exceeded_next    = exceeded_reg;
        inactive_next    = inactive_reg;
        acc_next         = acc_reg;
        prod_next        = prod_reg;
        prod_neg_next    = prod_neg_reg;
        l1_next          = l1_reg;
        den_next         = den_reg;
        z_next           = z_reg;
        nv_next          = nv_reg;
        delta_next       = delta_reg;
        dvd_next         = dvd_reg;
        rem_next         = rem_reg;
        dvs_next         = dvs_reg;
        div_cnt_next     = div_cnt_reg;
        div_neg_next     = div_neg_reg;
        div_phase_next   = div_phase_reg;
        x_we             = 1'b0;
        y_we             = 1'b0;
        r_we             = 1'b0;
        r_wdata          = sat32(acc_reg);
        coef_we          = 1'b0;
        coef_wsel        = j_reg;
        coef_wdata       = nv_reg;
        mul_a            = {x_rdata[DW-1], x_rdata};
        mul_b            = {r_rdata[DW-1], r_rdata};

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    unique case (encd_pkg::func_t'(s_func))
                        encd_pkg::FUNC_LOAD_X: begin
                            x_we = (32'(s_row) < ROWS_MAX) && (32'(s_column) < COLS_MAX);
                        end
                        encd_pkg::FUNC_LOAD_Y: begin
                            y_we = 32'(s_row) < ROWS_MAX;
                        end
                        encd_pkg::FUNC_LOAD_COEF: begin
                            coef_we    = 32'(s_column) < COLS_MAX;
                            coef_wsel  = CW'(s_column);
                            coef_wdata = s_value;
                        end
                        encd_pkg::FUNC_RUN: begin
                            n_next     = NW'(n_full);
                            n_m1_next  = RW'(n_full - 32'd1);
                            d_m1_next  = CW'(d_full - 32'd1);
                            state_next = S_LAM1;
                        end
                        default: ;
                    endcase
                end
            end
            S_LAM1: begin
                mul_a      = encd_pkg::OPND_W'(alpha_c);
                mul_b      = encd_pkg::OPND_W'(lambda_reg);
                prod_next  = mul_prod;
                state_next = S_LAM2;
            end
            S_LAM2: begin
                mul_a      = encd_pkg::OPND_W'(encd_pkg::ALPHA_ONE - alpha_c);
                mul_b      = encd_pkg::OPND_W'(lambda_reg);
                l1_next    = lam_rnd[DW-1:0];
                prod_next  = mul_prod;
                state_next = S_LAM3;
            end
            S_LAM3: begin
                den_next         = DEN_ONE + encd_pkg::DVS_W'(lam_rnd[DW-1:0]);
                i_next           = '0;
                inactive_next    = '0;
                active_only_next = 1'b0;
                rounds_next      = '0;
                state_next       = S_RI_Y_ADDR;
            end
            // residual init: r[i] = y[i] - sum_j x[j][i]*coef[j]
            S_RI_Y_ADDR: state_next = S_RI_Y_LOAD;
            S_RI_Y_LOAD: begin
                acc_next   = {{(AW-DW){y_rdata[DW-1]}}, y_rdata};
                j_next     = '0;
                state_next = S_RI_X_ADDR;
            end
            S_RI_X_ADDR: state_next = S_RI_X_MUL;
            S_RI_X_MUL: begin
                mul_b         = old33;
                prod_next     = mul_prod;
                prod_neg_next = mul_neg;
                state_next    = S_RI_X_ACC;
            end
            S_RI_X_ACC: begin
                acc_next = acc_reg - mulq;
                if (j_reg == d_m1_reg) begin
                    state_next = S_RI_WRITE;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_RI_X_ADDR;
                end
            end
            S_RI_WRITE: begin
                r_we = 1'b1;
                if (i_reg == n_m1_reg) begin
                    state_next = S_ROUND_CHECK;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_RI_Y_ADDR;
                end
            end
            S_ROUND_CHECK: begin
                j_next = '0;
                if (rounds_reg >= max_rounds_reg) begin
                    state_next = S_OUT;
                end else begin
                    rounds_next   = rounds_reg + 1'b1;
                    exceeded_next = 1'b0;
                    if (!active_only_reg) begin
                        inactive_next = '0;
                    end
                    state_next = S_COL_CHECK;
                end
            end
            S_COL_CHECK: begin
                if (inactive_reg[j_reg]) begin
                    state_next = S_COL_NEXT;
                end else begin
                    acc_next   = '0;
                    i_next     = '0;
                    state_next = S_CD_ADDR;
                end
            end
            // dot product of column j with the residuals
            S_CD_ADDR: state_next = S_CD_MUL;
            S_CD_MUL: begin
                prod_next     = mul_prod;
                prod_neg_next = mul_neg;
                state_next    = S_CD_ACC;
            end
            S_CD_ACC: begin
                acc_next = acc_reg + mulq;
                if (i_reg == n_m1_reg) begin
                    state_next = S_SUM_DIV;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_CD_ADDR;
                end
            end
            S_SUM_DIV: begin
                // round half away from zero: add half the divisor to the magnitude
                dvd_next       = acc_mag[encd_pkg::DVD_W-1:0]
                               + encd_pkg::DVD_W'(n_reg >> 1);
                dvs_next       = encd_pkg::DVS_W'(n_reg);
                div_neg_next   = acc_reg[AW-1];
                rem_next       = '0;
                div_cnt_next   = '0;
                div_phase_next = 1'b0;
                state_next     = S_DIV;
            end
            S_DIV: begin
                rem_next     = rem_ge ? rem_sub : rem_sh;
                dvd_next     = {dvd_reg[encd_pkg::DVD_W-2:0], rem_ge};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST) begin
                    state_next = div_phase_reg ? S_NV : S_Z;
                end
            end
            S_Z: begin
                z_next     = sat32(old_ext + q_s);
                state_next = S_Z2;
            end
            S_Z2: begin
                if (z_mag > {1'b0, l1_reg}) begin
                    dvd_next       = (encd_pkg::DVD_W'(z_diff) << FRAC_BITS)
                                   + encd_pkg::DVD_W'(den_reg >> 1);
                    dvs_next       = den_reg;
                    div_neg_next   = z_reg[DW-1];
                    rem_next       = '0;
                    div_cnt_next   = '0;
                    div_phase_next = 1'b1;
                    state_next     = S_DIV;
                end else begin
                    nv_next              = '0;
                    inactive_next[j_reg] = 1'b1;
                    state_next           = S_DELTA;
                end
            end
            S_NV: begin
                nv_next    = sat32(q_s);
                state_next = S_DELTA;
            end
            S_DELTA: begin
                delta_next = delta_calc;
                coef_we    = 1'b1;
                if (delta_mag > (DW+1)'(tol_reg)) begin
                    exceeded_next = 1'b1;
                end
                if (delta_calc != '0) begin
                    i_next     = '0;
                    state_next = S_RU_ADDR;
                end else begin
                    state_next = S_COL_NEXT;
                end
            end
            // residual update: r[i] -= x[j][i]*delta
            S_RU_ADDR: state_next = S_RU_MUL;
            S_RU_MUL: begin
                mul_b         = delta_reg;
                prod_next     = mul_prod;
                prod_neg_next = mul_neg;
                state_next    = S_RU_WRITE;
            end
            S_RU_WRITE: begin
                r_we    = 1'b1;
                r_wdata = sat32({{(AW-DW){r_rdata[DW-1]}}, r_rdata} - mulq);
                if (i_reg == n_m1_reg) begin
                    state_next = S_COL_NEXT;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_RU_ADDR;
                end
            end
            S_COL_NEXT: begin
                if (j_reg == d_m1_reg) begin
                    state_next = S_ROUND_END;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_COL_CHECK;
                end
            end
            S_ROUND_END: begin
                j_next = '0;
                if (active_only_reg) begin
                    if (!exceeded_reg) begin
                        active_only_next = 1'b0;
                    end
                    state_next = S_ROUND_CHECK;
                end else if (!exceeded_reg) begin
                    state_next = S_OUT;
                end else begin
                    active_only_next = 1'b1;
                    state_next       = S_ROUND_CHECK;
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    if (j_reg == d_m1_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        i_reg         <= i_next;
        j_reg         <= j_next;
        n_m1_reg      <= n_m1_next;
        n_reg         <= n_next;
        d_m1_reg      <= d_m1_next;
        exceeded_reg  <= exceeded_next;
        acc_reg       <= acc_next;
        prod_reg      <= prod_next;
        prod_neg_reg  <= prod_neg_next;
        l1_reg        <= l1_next;
        den_reg       <= den_next;
        z_reg         <= z_next;
        nv_reg        <= nv_next;
        delta_reg     <= delta_next;
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        dvs_reg       <= dvs_next;
        div_cnt_reg   <= div_cnt_next;
        div_neg_reg   <= div_neg_next;
        div_phase_reg <= div_phase_next;
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            rounds_reg      <= '0;
            active_only_reg <= 1'b0;
            inactive_reg    <= '0;
        end else begin
            state_reg       <= state_next;
            rounds_reg      <= rounds_next;
            active_only_reg <= active_only_next;
            inactive_reg    <= inactive_next;
        end
    end

    // ---------------- ports ----------------
    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = (state_reg == S_OUT);
    assign m_last        = (j_reg == d_m1_reg);
    assign m_coef_index  = encd_pkg::IDX_W'(j_reg);
    assign m_coef_value  = coef_rd;
    assign m_rounds_done = m_last ? rounds_reg : '0;

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while results pending");

    a_rounds_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> (m_rounds_done == '0))
        else $error("rounds_done set on a non-final item");

    a_round_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (rounds_reg <= max_rounds_reg))
        else $error("round count beyond limit");

    a_res_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        r_we |-> !s_ready)
        else $error("residual write while idle");

    a_back_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> s_ready)
        else $error("not idle after final item");
`endif

endmodule

`default_nettype wire

>>> tb/encd_fit_checker.sv
// Checker for elastic_net_coordinate_descent: watches the config, input and result channels.
// It predicts each fit in fixed point and compares every result field. Depends on encd_pkg.
`default_nettype none

module encd_fit_checker (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_valid,
    input  wire logic                                 cfg_ready,
    input  wire logic [encd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [encd_pkg::DATA_W-1:0]          cfg_data,
    input  wire logic                                 s_valid,
    input  wire logic                                 s_ready,
    input  wire logic [encd_pkg::FUNC_W-1:0]          s_func,
    input  wire logic [encd_pkg::ROW_W-1:0]           s_row,
    input  wire logic [encd_pkg::COL_W-1:0]           s_column,
    input  wire logic signed [encd_pkg::DATA_W-1:0]   s_value,
    input  wire logic                                 m_valid,
    input  wire logic                                 m_ready,
    input  wire logic [encd_pkg::IDX_W-1:0]           m_coef_index,
    input  wire logic signed [encd_pkg::DATA_W-1:0]   m_coef_value,
    input  wire logic [encd_pkg::ROUND_W-1:0]         m_rounds_done,
    input  wire logic                                 m_last,
    output int                                        fail_count,
    output int                                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS = 1024;
    localparam int COLS = 32;

    typedef struct {
        logic [encd_pkg::IDX_W-1:0]   idx;
        logic [encd_pkg::DATA_W-1:0]  value;
        logic [encd_pkg::ROUND_W-1:0] rounds;
        logic                         last;
    } coef_result_t;

    coef_result_t coef_q[$];

    int  x_mem [0:COLS*ROWS-1];
    int  y_mem [0:ROWS-1];
    int  resid [0:ROWS-1];
    int  coef  [0:COLS-1];
    bit  skip  [0:COLS-1];

    logic [encd_pkg::LAMBDA_W-1:0] lambda_r;
    logic [encd_pkg::ALPHA_W-1:0]  alpha_r;
    logic [encd_pkg::TOL_W-1:0]    tol_r;
    logic [encd_pkg::ROUND_W-1:0]  max_rounds_r;
    logic [encd_pkg::ROWCNT_W-1:0] rows_r;
    logic [encd_pkg::COLCNT_W-1:0] cols_r;

    function automatic longint unsigned amag(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic longint apply_sign(longint unsigned m, bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Q16.16 product, rounded half away from zero
    function automatic longint qmul(longint a, longint b);
        longint unsigned m;
        m = amag(a) * amag(b);
        m = (m + 64'd32768) >> 16;
        return apply_sign(m, (a < 0) != (b < 0));
    endfunction

    function automatic longint div_rnd(longint num, longint unsigned den);
        longint unsigned m;
        m = (amag(num) + den / 2) / den;
        return apply_sign(m, num < 0);
    endfunction

    task automatic predict_fit();
        int n, d, rounds;
        longint unsigned a, l1, l2, den;
        longint acc, sum, z, delta, old, num, nv;
        bit active_only, exceeded;
        coef_result_t r;
        n = (rows_r < 1) ? 1 : (rows_r > ROWS) ? ROWS : rows_r;
        d = (cols_r < 1) ? 1 : (cols_r > COLS) ? COLS : cols_r;
        a = (alpha_r > encd_pkg::ALPHA_ONE) ? 64'd65536 : 64'(alpha_r);
        l1 = (a * lambda_r + 64'd32768) >> 16;
        l2 = ((64'd65536 - a) * lambda_r + 64'd32768) >> 16;
        den = 64'd65536 + l2;
        for (int i = 0; i < n; i++) begin
            acc = y_mem[i];
            for (int j = 0; j < d; j++) acc -= qmul(x_mem[j*ROWS+i], coef[j]);
            resid[i] = int'(sat32(acc));
        end
        active_only = 0;
        foreach (skip[j]) skip[j] = 0;
        rounds = 0;
        while (rounds < max_rounds_r) begin
            exceeded = 0;
            rounds++;
            if (!active_only) foreach (skip[j]) skip[j] = 0;
            for (int j = 0; j < d; j++) begin
                if (skip[j]) continue;
                old = coef[j];
                sum = 0;
                for (int i = 0; i < n; i++) sum += qmul(x_mem[j*ROWS+i], resid[i]);
                z = sat32(old + div_rnd(sum, longint'(n)));
                if (amag(z) > l1) begin
                    num = (z > 0) ? z - longint'(l1) : z + longint'(l1);
                    nv = sat32(div_rnd(apply_sign(amag(num) << 16, num < 0), den));
                    delta = nv - old;
                    coef[j] = int'(nv);
                end else begin
                    delta = -old;
                    coef[j] = 0;
                    skip[j] = 1;
                end
                if (amag(delta) > tol_r) exceeded = 1;
                if (delta != 0)
                    for (int i = 0; i < n; i++)
                        resid[i] = int'(sat32(longint'(resid[i]) - qmul(x_mem[j*ROWS+i], delta)));
            end
            if (active_only) begin
                if (!exceeded) active_only = 0;
            end else begin
                if (!exceeded) break;
                active_only = 1;
            end
        end
        for (int k = 0; k < d; k++) begin
            r.idx    = k[encd_pkg::IDX_W-1:0];
            r.value  = coef[k];
            r.last   = (k == d - 1);
            r.rounds = r.last ? rounds[encd_pkg::ROUND_W-1:0] : '0;
            coef_q.push_back(r);
        end
    endtask

    assign pending = coef_q.size();

    initial fail_count = 0;

    always @(posedge aclk) begin
        coef_result_t e;
        if (!aresetn) begin
            lambda_r     <= encd_pkg::LAMBDA_RST;
            alpha_r      <= encd_pkg::ALPHA_RST;
            tol_r        <= encd_pkg::TOL_RST;
            max_rounds_r <= encd_pkg::MAX_ROUNDS_RST;
            rows_r       <= encd_pkg::ROW_COUNT_RST;
            cols_r       <= encd_pkg::COL_COUNT_RST;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (encd_pkg::cfg_reg_t'(cfg_index))
                    encd_pkg::REG_LAMBDA:     lambda_r <= cfg_data[encd_pkg::LAMBDA_W-1:0];
                    encd_pkg::REG_ALPHA:      alpha_r  <= cfg_data[encd_pkg::ALPHA_W-1:0];
                    encd_pkg::REG_TOL:        tol_r    <= cfg_data[encd_pkg::TOL_W-1:0];
                    encd_pkg::REG_MAX_ROUNDS: max_rounds_r <= cfg_data[encd_pkg::ROUND_W-1:0];
                    encd_pkg::REG_ROW_COUNT:  rows_r   <= cfg_data[encd_pkg::ROWCNT_W-1:0];
                    encd_pkg::REG_COL_COUNT:  cols_r   <= cfg_data[encd_pkg::COLCNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                case (encd_pkg::func_t'(s_func))
                    encd_pkg::FUNC_LOAD_X:    x_mem[s_column*ROWS + s_row] = s_value;
                    encd_pkg::FUNC_LOAD_Y:    y_mem[s_row] = s_value;
                    encd_pkg::FUNC_LOAD_COEF: coef[s_column] = s_value;
                    encd_pkg::FUNC_RUN:       predict_fit();
                endcase
            end
            if (m_valid && m_ready) begin
                if (coef_q.size() == 0) begin
                    $error("unexpected result item: index %0d value %0d",
                           m_coef_index, m_coef_value);
                    fail_count++;
                end else begin
                    e = coef_q.pop_front();
                    if (m_coef_index !== e.idx) begin
                        $error("coef_index: expected %0d, got %0d", e.idx, m_coef_index);
                        fail_count++;
                    end
                    if (m_coef_value !== e.value) begin
                        $error("coef_value: expected %0d, got %0d",
                               $signed(e.value), m_coef_value);
                        fail_count++;
                    end
                    if (m_rounds_done !== e.rounds) begin
                        $error("rounds_done: expected %0d, got %0d", e.rounds, m_rounds_done);
                        fail_count++;
                    end
                    if (m_last !== e.last) begin
                        $error("last: expected %0d, got %0d", e.last, m_last);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> tb/tb_elastic_net_coordinate_descent.sv
// Testbench top for elastic_net_coordinate_descent: clock, reset, stimulus and verdict.
// Depends on encd_pkg, the block and encd_fit_checker.
`default_nettype none

module tb_elastic_net_coordinate_descent;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 4000000;

    logic aclk, aresetn;
    logic cfg_valid, cfg_ready;
    logic [encd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [encd_pkg::DATA_W-1:0] cfg_data;
    logic s_valid, s_ready;
    logic [encd_pkg::FUNC_W-1:0] s_func;
    logic [encd_pkg::ROW_W-1:0] s_row;
    logic [encd_pkg::COL_W-1:0] s_column;
    logic signed [encd_pkg::DATA_W-1:0] s_value;
    logic m_valid, m_ready;
    logic [encd_pkg::IDX_W-1:0] m_coef_index;
    logic signed [encd_pkg::DATA_W-1:0] m_coef_value;
    logic [encd_pkg::ROUND_W-1:0] m_rounds_done;
    logic m_last;
    int fail_count, pending;

    int items;
    int cycles;
    bit x_wr [0:31][0:1023];
    bit y_wr [0:1023];
    bit coef_wr [0:31];
    bit stall_on;
    int stall_hold;

    elastic_net_coordinate_descent u_top (.*);

    encd_fit_checker u_checker (.*);

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver stalls; stretches with stall_on low start no new stalls
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
            m_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_on <= ~stall_on;
            if (stall_on && $urandom_range(0, 3) == 0) begin
                stall_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                          : $urandom_range(0, 3);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 19);
        if (k < 12) return 0;
        if (k < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [encd_pkg::DATA_W-1:0] rand_value();
        if ($urandom_range(0, 7) == 0) return $urandom;
        return encd_pkg::DATA_W'($signed($urandom_range(0, 131072)) - 65536);
    endfunction

    task automatic send_item(encd_pkg::func_t f, int r, int c,
                             logic [encd_pkg::DATA_W-1:0] v);
        int g;
        g = gap_len();
        repeat (g) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
        @(negedge aclk);
        s_valid  = 1'b1;
        s_func   = f;
        s_row    = r[encd_pkg::ROW_W-1:0];
        s_column = c[encd_pkg::COL_W-1:0];
        s_value  = v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items++;
        case (f)
            encd_pkg::FUNC_LOAD_X:    x_wr[c][r] = 1;
            encd_pkg::FUNC_LOAD_Y:    y_wr[r] = 1;
            encd_pkg::FUNC_LOAD_COEF: coef_wr[c] = 1;
            default: ;
        endcase
    endtask

    // all results back, then let a trailing load settle
    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic cfg_write(encd_pkg::cfg_reg_t idx, logic [encd_pkg::DATA_W-1:0] d);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // load what the fit reads and is unwritten (if fresh, all x and y, some coefs)
    task automatic load_problem(int n, int d, bit fresh);
        for (int j = 0; j < d; j++)
            for (int i = 0; i < n; i++)
                if (fresh || !x_wr[j][i])
                    send_item(encd_pkg::FUNC_LOAD_X, i, j, rand_value());
        for (int i = 0; i < n; i++)
            if (fresh || !y_wr[i]) send_item(encd_pkg::FUNC_LOAD_Y, i, 0, rand_value());
        for (int j = 0; j < d; j++)
            if ((fresh && $urandom_range(0, 1)) || !coef_wr[j])
                send_item(encd_pkg::FUNC_LOAD_COEF, 0, j, rand_value());
    endtask

    initial begin
        int n, d;
        items = 0;
        cycles = 0;
        stall_on = 0;
        stall_hold = 0;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_func = encd_pkg::FUNC_LOAD_X;
        s_row = '0;
        s_column = '0;
        s_value = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: extreme values, saturation, all functions
        cfg_write(encd_pkg::REG_ROW_COUNT, 2);
        cfg_write(encd_pkg::REG_COL_COUNT, 2);
        cfg_write(encd_pkg::REG_MAX_ROUNDS, 20);
        send_item(encd_pkg::FUNC_LOAD_X, 0, 0, 32'h8000_0000);
        send_item(encd_pkg::FUNC_LOAD_X, 1, 0, 32'h7fff_ffff);
        send_item(encd_pkg::FUNC_LOAD_X, 0, 1, 32'h0001_0000);
        send_item(encd_pkg::FUNC_LOAD_X, 1, 1, -32'sd32768);
        send_item(encd_pkg::FUNC_LOAD_Y, 0, 0, 32'h7fff_ffff);
        send_item(encd_pkg::FUNC_LOAD_Y, 1, 0, -32'sd100000);
        send_item(encd_pkg::FUNC_LOAD_COEF, 0, 0, 32'h0);
        send_item(encd_pkg::FUNC_LOAD_COEF, 0, 1, 32'h8000_0000);
        send_item(encd_pkg::FUNC_RUN, 0, 0, 0);
        wait_idle();
        // zero round limit, warm start
        cfg_write(encd_pkg::REG_MAX_ROUNDS, 0);
        send_item(encd_pkg::FUNC_RUN, 0, 0, 0);
        wait_idle();
        // heavy L1: everything drops to zero quickly
        cfg_write(encd_pkg::REG_LAMBDA, 32'h7fff_ffff);
        cfg_write(encd_pkg::REG_ALPHA, 65536);
        cfg_write(encd_pkg::REG_MAX_ROUNDS, 65535);
        send_item(encd_pkg::FUNC_LOAD_X, 0, 0, 32'h0000_8000);
        send_item(encd_pkg::FUNC_LOAD_X, 1, 0, 32'hffff_4000);
        send_item(encd_pkg::FUNC_LOAD_COEF, 0, 0, 32'h0002_0000);
        send_item(encd_pkg::FUNC_RUN, 0, 0, 0);
        wait_idle();
        // alpha above one clamps, no penalty, huge tolerance
        cfg_write(encd_pkg::REG_ALPHA, 32'h0001_ffff);
        cfg_write(encd_pkg::REG_LAMBDA, 0);
        cfg_write(encd_pkg::REG_TOL, 32'h7fff_ffff);
        send_item(encd_pkg::FUNC_RUN, 0, 0, 0);
        wait_idle();
        // pure L2, zero tolerance, counts clamp up to one
        cfg_write(encd_pkg::REG_ALPHA, 0);
        cfg_write(encd_pkg::REG_LAMBDA, 65536);
        cfg_write(encd_pkg::REG_TOL, 0);
        cfg_write(encd_pkg::REG_ROW_COUNT, 0);
        cfg_write(encd_pkg::REG_COL_COUNT, 0);
        cfg_write(encd_pkg::REG_MAX_ROUNDS, 30);
        send_item(encd_pkg::FUNC_RUN, 0, 0, 0);
        wait_idle();

        // widest column set, a column count beyond range clamps to the maximum
        cfg_write(encd_pkg::REG_COL_COUNT, 63);
        cfg_write(encd_pkg::REG_ROW_COUNT, 1);
        cfg_write(encd_pkg::REG_MAX_ROUNDS, 6);
        cfg_write(encd_pkg::REG_TOL, 66);
        cfg_write(encd_pkg::REG_ALPHA, 32768);
        load_problem(1, 32, 1);
        send_item(encd_pkg::FUNC_RUN, 0, 0, 0);
        wait_idle();

        while (items < 130) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
            d = $urandom_range(1, 6);
            cfg_write(encd_pkg::REG_ROW_COUNT, n);
            cfg_write(encd_pkg::REG_COL_COUNT, d);
            cfg_write(encd_pkg::REG_MAX_ROUNDS, $urandom_range(1, 25));
            if ($urandom_range(0, 1))
                cfg_write(encd_pkg::REG_LAMBDA,
                          ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 131072));
            if ($urandom_range(0, 1))
                cfg_write(encd_pkg::REG_ALPHA, $urandom_range(0, 65536));
            if ($urandom_range(0, 2) == 0)
                cfg_write(encd_pkg::REG_TOL, $urandom_range(0, 4000));
            load_problem(n, d, $urandom_range(0, 2) == 0);
            // stray loads anywhere in the stores
            repeat ($urandom_range(0, 3)) begin
                case ($urandom_range(0, 2))
                    0: send_item(encd_pkg::FUNC_LOAD_X, $urandom_range(0, 1023),
                                 $urandom_range(0, 31), $urandom);
                    1: send_item(encd_pkg::FUNC_LOAD_Y, $urandom_range(0, 1023),
                                 $urandom_range(0, 31), $urandom);
                    default: send_item(encd_pkg::FUNC_LOAD_COEF, $urandom_range(0, 1023),
                                       $urandom_range(0, 31), rand_value());
                endcase
            end
            send_item(encd_pkg::FUNC_RUN, $urandom_range(0, 1023), $urandom_range(0, 31),
                      $urandom);
            wait_idle();
        end

        @(negedge aclk);
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
